>>> rtl/tpk_pkg.sv
// ----------------------------------------------------------------------------
// tpk_pkg
// Shared types and constants of the position keeper: record layout, request
// codes, status codes, sequencer states and the arithmetic unit command.
// ----------------------------------------------------------------------------
package tpk_pkg;

  localparam int VOL_W   = 31;
  localparam int PRICE_W = 47;
  localparam int PNL_W   = 64;
  localparam int QTY_W   = 32;
  localparam int SIZE_W  = 16;
  localparam int TKR_W   = 8;
  localparam int MUL_W   = 48;
  localparam int DVD_W   = 80;

  localparam logic [VOL_W-1:0] VOL_MAX = {VOL_W{1'b1}};

  localparam logic [1:0] ACT_PEND   = 2'd0;
  localparam logic [1:0] ACT_FILL   = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_PEND_CLAMP = 2'd1;
  localparam logic [1:0] STAT_VOL_CLAMP  = 2'd2;

  localparam logic [PNL_W-1:0] PNL_MAX = {1'b0, {(PNL_W-1){1'b1}}};
  localparam logic [PNL_W-1:0] PNL_MIN = {1'b1, {(PNL_W-1){1'b0}}};

  typedef struct packed {
    logic [VOL_W-1:0]   vol;
    logic [VOL_W-1:0]   opn;
    logic [VOL_W-1:0]   cls;
    logic [PRICE_W-1:0] cost;
    logic [PNL_W-1:0]   flt;
  } side_rec_t;

  // sd[0] is the long side, sd[1] the short side
  typedef struct packed {
    logic            valid;
    side_rec_t [1:0] sd;
  } entry_t;

  typedef enum logic {ALU_MUL, ALU_DIV} alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_cmd_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_LOAD, S_APPLY, S_TICK, S_M1, S_W1, S_M2, S_W2,
    S_SAT, S_DV, S_W3, S_COST, S_WRITE, S_OUT0, S_OUT1
  } tpk_state_t;

endpackage

>>> rtl/trading_position_keeper.sv
// ----------------------------------------------------------------------------
// trading_position_keeper
// Per-instrument long/short position table with pending counts, fills,
// cost re-averaging and floating/realized profit.
// ----------------------------------------------------------------------------
// One request is handled at a time; in_stall is low only while idle. After
// reset a clearing pass zeroes the table before the first request is taken.
// All multiplies and the cost division run on one shared shift-add/restoring
// unit at one bit per cycle: a closing fill uses two 48-step multiplies, an
// opening fill a 48-step multiply plus an 80-step divide and a price tick two
// multiplies for each side holding volume, while a pending change needs none.
// Each result is then held until the receiver takes it.
module trading_position_keeper import tpk_pkg::*; #(
  parameter int INSTRUMENTS = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_action,
  input  logic [TKR_W-1:0]    in_ticker,
  input  logic                in_direction,
  input  logic                in_closing,
  input  logic [QTY_W-1:0]    in_quantity,
  input  logic [PRICE_W-1:0]  in_price,
  input  logic [SIZE_W-1:0]   in_contract_size,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [TKR_W-1:0]    out_ticker,
  output logic                out_side,
  output logic                out_last,
  output logic [1:0]          out_status,
  output logic [VOL_W-1:0]    out_volume,
  output logic [VOL_W-1:0]    out_open_pend,
  output logic [VOL_W-1:0]    out_close_pend,
  output logic [PRICE_W-1:0]  out_avg_cost,
  output logic [PNL_W-1:0]    out_float_profit,
  output logic [PNL_W-1:0]    out_realized_profit
);

  localparam int IDXW = (INSTRUMENTS > 1) ? $clog2(INSTRUMENTS) : 1;

  tpk_state_t          st_r, st_nxt;
  entry_t              mem [INSTRUMENTS];
  entry_t              rd_data_r;
  entry_t              wrk_r;
  logic [IDXW-1:0]     clr_r;
  logic [1:0]          act_r;
  logic [TKR_W-1:0]    tkr_r;
  logic                cls_r;
  logic [QTY_W-1:0]    qty_r;
  logic [PRICE_W-1:0]  price_r;
  logic [SIZE_W-1:0]   size_r;
  logic                s_r;
  logic [1:0]          status_r;
  logic [PNL_W-1:0]    realized_r;
  logic [PRICE_W-1:0]  mag_r;
  logic                neg_r;
  logic                ge_r;
  logic [MUL_W-1:0]    opa_r;
  logic [MUL_W-1:0]    opb_r;

  logic                in_acc;
  logic                mem_we;
  logic [IDXW-1:0]     mem_wa;
  entry_t              mem_wd;
  logic                drop;

  alu_cmd_t            alu_cmd;
  logic                alu_done;
  logic [2*MUL_W-1:0]  alu_prod;
  logic [DVD_W-1:0]    alu_quo;
  logic                alu_rem;

  side_rec_t           cur;
  side_rec_t           side_new;
  logic [VOL_W-1:0]    pend_cur;
  logic [VOL_W-1:0]    pend_new;
  logic [33:0]         pend_sum;
  logic [PRICE_W:0]    diff;
  logic [PRICE_W-1:0]  mag;
  logic                neg;
  logic [32:0]         vol_dec;
  logic [31:0]         vol_inc;
  logic [VOL_W-1:0]    vol_new;
  logic                vol_clamp;
  logic [1:0]          status_new;
  logic [MUL_W-1:0]    opa_new;
  logic [MUL_W-1:0]    opb_new;
  logic [PNL_W-1:0]    sat;
  logic [PRICE_W-1:0]  quo;
  side_rec_t           out_rec;

  assign in_acc = in_valid && !in_stall;

  // table memory
  always_comb begin
    mem_we = (st_r == S_CLEAR) || (st_r == S_WRITE);
    mem_wa = (st_r == S_CLEAR) ? clr_r : IDXW'(tkr_r);
    mem_wd = (st_r == S_CLEAR) ? '0 : wrk_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (in_acc) rd_data_r <= mem[IDXW'(in_ticker)];
  end

  tpk_alu u_alu (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (alu_cmd),
    .a_i      (opa_r),
    .b_i      (opb_r),
    .dvd_i    (alu_prod[DVD_W-1:0]),
    .dvs_i    (cur.vol),
    .done_o   (alu_done),
    .prod_o   (alu_prod),
    .quo_o    (alu_quo),
    .rem_nz_o (alu_rem)
  );

  // drop requests that are invalid or leave everything unchanged
  always_comb begin
    drop = 1'b0;
    if (32'(tkr_r) >= INSTRUMENTS) begin
      drop = 1'b1;
    end else begin
      case (act_r)
        ACT_PEND: drop = (qty_r == '0);
        ACT_FILL: drop = qty_r[QTY_W-1] || (qty_r == '0);
        ACT_TICK: drop = !rd_data_r.valid || (size_r == '0) ||
                         ((rd_data_r.sd[0].vol == '0) && (rd_data_r.sd[1].vol == '0));
        default:  drop = 1'b1;
      endcase
    end
  end

  // record update for pending changes and fills, with price difference and product saturation
  always_comb begin
    cur      = wrk_r.sd[s_r];
    pend_cur = cls_r ? cur.cls : cur.opn;
    diff     = {1'b0, price_r} - {1'b0, cur.cost};
    mag      = diff[PRICE_W] ? PRICE_W'(-diff) : diff[PRICE_W-1:0];
    neg      = s_r ? (!diff[PRICE_W] && (diff != '0)) : diff[PRICE_W];
    if (act_r == ACT_PEND) begin
      pend_sum = {3'b0, pend_cur} + {{2{qty_r[QTY_W-1]}}, qty_r};
    end else begin
      pend_sum = {3'b0, pend_cur} - {2'b0, qty_r};
    end
    if (pend_sum[33]) pend_new = '0;
    else if (|pend_sum[32:31]) pend_new = VOL_MAX;
    else pend_new = pend_sum[VOL_W-1:0];

    vol_dec   = {2'b0, cur.vol} - {1'b0, qty_r};
    vol_inc   = {1'b0, cur.vol} + qty_r;
    vol_clamp = 1'b0;
    if (cls_r) begin
      vol_clamp = vol_dec[32];
      vol_new   = vol_dec[32] ? '0 : vol_dec[VOL_W-1:0];
    end else begin
      vol_new   = vol_inc[31] ? VOL_MAX : vol_inc[VOL_W-1:0];
    end

    side_new = cur;
    if (cls_r) side_new.cls = pend_new;
    else       side_new.opn = pend_new;

    status_new = pend_sum[33] ? STAT_PEND_CLAMP : STAT_OK;
    opa_new    = {32'b0, size_r};
    opb_new    = {17'b0, qty_r[VOL_W-1:0]};
    if (act_r == ACT_FILL) begin
      side_new.vol = vol_new;
      if (vol_clamp) status_new = STAT_VOL_CLAMP;
      if (cls_r && vol_new == '0) begin
        side_new.cost = '0;
        side_new.flt  = '0;
      end
      if (!cls_r) begin
        opa_new = {1'b0, mag};
        opb_new = {17'b0, vol_new - cur.vol};
      end
    end

    quo = alu_quo[PRICE_W-1:0];

    // saturate the signed product to 64 bits
    if (!neg_r) begin
      sat = (|alu_prod[2*MUL_W-1:PNL_W-1]) ? PNL_MAX : alu_prod[PNL_W-1:0];
    end else if ((|alu_prod[2*MUL_W-1:PNL_W]) ||
                 (alu_prod[PNL_W-1] && (|alu_prod[PNL_W-2:0]))) begin
      sat = PNL_MIN;
    end else begin
      sat = -alu_prod[PNL_W-1:0];
    end
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_CLEAR: if (clr_r == IDXW'(INSTRUMENTS - 1)) st_nxt = S_IDLE;
      S_IDLE:  if (in_acc) st_nxt = S_LOAD;
      S_LOAD: begin
        if (drop) st_nxt = S_IDLE;
        else if (act_r == ACT_TICK) st_nxt = S_TICK;
        else st_nxt = S_APPLY;
      end
      S_APPLY: st_nxt = (act_r == ACT_PEND) ? S_WRITE : S_M1;
      S_TICK: begin
        if (cur.vol != '0) st_nxt = S_M1;
        else if (s_r) st_nxt = S_WRITE;
      end
      S_M1: st_nxt = S_W1;
      S_W1: if (alu_done) st_nxt = (act_r == ACT_FILL && !cls_r) ? S_DV : S_M2;
      S_M2: st_nxt = S_W2;
      S_W2: if (alu_done) st_nxt = S_SAT;
      S_SAT: st_nxt = (act_r == ACT_TICK && !s_r) ? S_TICK : S_WRITE;
      S_DV: st_nxt = S_W3;
      S_W3: if (alu_done) st_nxt = S_COST;
      S_COST: st_nxt = S_WRITE;
      S_WRITE: st_nxt = (act_r == ACT_TICK) ? S_OUT0 : S_OUT1;
      S_OUT0: if (!out_stall) st_nxt = S_OUT1;
      S_OUT1: if (!out_stall) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall      = (st_r != S_IDLE);
    out_valid     = (st_r == S_OUT0) || (st_r == S_OUT1);
    alu_cmd.start = (st_r == S_M1) || (st_r == S_M2) || (st_r == S_DV);
    alu_cmd.op    = (st_r == S_DV) ? ALU_DIV : ALU_MUL;
    out_side      = (st_r == S_OUT0) ? 1'b0 : s_r;
    out_last      = (st_r == S_OUT1);
    out_rec       = wrk_r.sd[out_side];
  end

  assign out_ticker          = tkr_r;
  assign out_status          = status_r;
  assign out_volume          = out_rec.vol;
  assign out_open_pend       = out_rec.opn;
  assign out_close_pend      = out_rec.cls;
  assign out_avg_cost        = out_rec.cost;
  assign out_float_profit    = out_rec.flt;
  assign out_realized_profit = realized_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_CLEAR;
      clr_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_CLEAR) clr_r <= clr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          act_r      <= in_action;
          tkr_r      <= in_ticker;
          cls_r      <= in_closing;
          qty_r      <= in_quantity;
          price_r    <= in_price;
          size_r     <= in_contract_size;
          s_r        <= (in_action == ACT_TICK) ? 1'b0 : (in_closing ^ in_direction);
          status_r   <= STAT_OK;
          realized_r <= '0;
        end
      end
      S_LOAD: wrk_r <= rd_data_r;
      S_APPLY: begin
        wrk_r.valid    <= 1'b1;
        wrk_r.sd[s_r]  <= side_new;
        status_r       <= status_new;
        mag_r          <= mag;
        neg_r          <= neg;
        ge_r           <= !diff[PRICE_W];
        opa_r          <= opa_new;
        opb_r          <= opb_new;
      end
      S_TICK: begin
        mag_r <= mag;
        neg_r <= neg;
        opa_r <= {32'b0, size_r};
        opb_r <= {17'b0, cur.vol};
        // skip a side without volume
        if (cur.vol == '0 && !s_r) s_r <= 1'b1;
      end
      S_W1: begin
        if (alu_done) begin
          opa_r <= alu_prod[MUL_W-1:0];
          opb_r <= {1'b0, mag_r};
        end
      end
      S_SAT: begin
        if (act_r == ACT_TICK) begin
          wrk_r.sd[s_r].flt <= sat;
          if (!s_r) s_r <= 1'b1;
        end else begin
          realized_r <= sat;
        end
      end
      S_COST: begin
        wrk_r.sd[s_r].cost <= ge_r ? (cur.cost + quo)
                                   : (cur.cost - quo - PRICE_W'(alu_rem));
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/tpk_alu.sv
// ----------------------------------------------------------------------------
// tpk_alu
// Shared shift-add multiplier and restoring divider around one 49-bit adder.
// A multiply takes 48 steps, a divide 80 steps.
// ----------------------------------------------------------------------------
module tpk_alu import tpk_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  alu_cmd_t             cmd,
  input  logic [MUL_W-1:0]     a_i,
  input  logic [MUL_W-1:0]     b_i,
  input  logic [DVD_W-1:0]     dvd_i,
  input  logic [VOL_W-1:0]     dvs_i,
  output logic                 done_o,
  output logic [2*MUL_W-1:0]   prod_o,
  output logic [DVD_W-1:0]     quo_o,
  output logic                 rem_nz_o
);

  logic               run_r;
  logic               done_r;
  alu_op_t            op_r;
  logic [6:0]         cnt_r;
  logic [MUL_W-1:0]   hi_r;
  logic [DVD_W-1:0]   lo_r;
  logic [MUL_W-1:0]   a_r;
  logic [31:0]        trial;
  logic [MUL_W:0]     add_a;
  logic [MUL_W:0]     add_b;
  logic [MUL_W:0]     sum;
  logic [6:0]         last_step;

  always_comb begin
    trial = {hi_r[30:0], lo_r[DVD_W-1]};
    if (op_r == ALU_MUL) begin
      add_a = {1'b0, hi_r};
      add_b = lo_r[0] ? {1'b0, a_r} : '0;
      sum   = add_a + add_b;
    end else begin
      add_a = {17'b0, trial};
      add_b = ~{1'b0, a_r};
      sum   = add_a + add_b + {{MUL_W{1'b0}}, 1'b1};
    end
    last_step = (op_r == ALU_MUL) ? 7'(MUL_W - 1) : 7'(DVD_W - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else if (cmd.start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
    end else if (run_r && cnt_r == last_step) begin
      run_r  <= 1'b0;
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r  <= cmd.op;
      cnt_r <= '0;
      hi_r  <= '0;
      a_r   <= (cmd.op == ALU_DIV) ? {17'b0, dvs_i} : a_i;
      lo_r  <= (cmd.op == ALU_DIV) ? dvd_i : {32'b0, b_i};
    end else if (run_r) begin
      cnt_r <= cnt_r + 7'd1;
      if (op_r == ALU_MUL) begin
        hi_r <= sum[MUL_W:1];
        lo_r <= {32'b0, sum[0], lo_r[MUL_W-1:1]};
      end else begin
        // keep the partial remainder when the trial subtract goes negative
        hi_r <= sum[MUL_W] ? {17'b0, trial[30:0]} : {17'b0, sum[30:0]};
        lo_r <= {lo_r[DVD_W-2:0], ~sum[MUL_W]};
      end
    end
  end

  assign done_o   = done_r;
  assign prod_o   = {hi_r, lo_r[MUL_W-1:0]};
  assign quo_o    = lo_r;
  assign rem_nz_o = |hi_r[30:0];

endmodule
